// ===== rtl/core/gsp_pkg.sv =====
package gsp_pkg;

    localparam int MAX_GRID_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    localparam int KIND_W  = 2;
    localparam int COORD_W = 7;
    localparam int SIZE_W  = 7;
    localparam int TOL_W   = 31;
    localparam int STEP_W  = 32;
    localparam int LIMIT_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [KIND_W-1:0] KIND_LOAD_POT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_SRC = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SOLVE    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SQ   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 2'd3;

    localparam logic [SIZE_W-1:0]  RST_GRID_SIZE = 7'd64;
    localparam logic [TOL_W-1:0]   RST_TOLERANCE = 31'd2684;
    localparam logic [STEP_W-1:0]  RST_STEP_SQ   = 32'd1016560;
    localparam logic [LIMIT_W-1:0] RST_LIMIT     = 16'd65535;

    // Commands from the controller to the datapath.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_WR_POT,
        OP_WR_SRC,
        OP_RD_POT,
        OP_FETCH,
        OP_CALC,
        OP_SAT,
        OP_STORE
    } t_op;

    typedef struct packed {
        t_op  op;
        logic sweep_start;
    } t_cmd;

    typedef struct packed {
        logic conv;
    } t_stat;

endpackage

// ===== rtl/core/gauss_seidel_poisson_solver.sv =====
// Gauss-Seidel Poisson solver, 5-point stencil, signed Q4.28 cells.
// Input channel (s_axis): tuser is the item kind, tdata holds row, col, value.
// Load potential and load source items give no result.
// A read item gives one result, taken from the registered potential memory read.
// A solve item sweeps rows 1..N, columns 1..N; each cell runs through the fetch,
// calc (multiply), saturate and store steps, with five reads (four neighbors, then
// the center) through the single read port of the potential memory; a check step ends each sweep.
// The result carries the sweep count and the converged flag.
// Configuration channel: index 0 grid size, 1 tolerance, 2 h squared,
// 3 sweep limit. The user must write it only while the block is idle; no check enforces it.
// Result channel (m_axis): tuser is the result kind. A result register holds
// the item until tready; no new item is taken while a result waits.
// Reset restores the register defaults; grid memories keep their contents,
// which are undefined until loaded.
module gauss_seidel_poisson_solver #(
    parameter int MAX_GRID   = gsp_pkg::MAX_GRID_DEF,
    parameter int VALUE_BITS = gsp_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,   // kind
    input  logic [((14 + VALUE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata, // row, col, value
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [gsp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gsp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [0:0]  m_axis_tuser,   // answer_kind
    output logic [((VALUE_BITS + 17 + 7) / 8) * 8 - 1:0] m_axis_tdata // cell_value, sweeps, converged
);

    localparam int SIDE = MAX_GRID + 2;
    localparam int PA_W = $clog2(SIDE * SIDE);
    localparam int SA_W = $clog2(MAX_GRID * MAX_GRID);
    localparam int OUT_W = ((VALUE_BITS + 17 + 7) / 8) * 8;

    logic [gsp_pkg::SIZE_W-1:0]  r_grid_size;
    logic [gsp_pkg::TOL_W-1:0]   r_tol;
    logic [gsp_pkg::STEP_W-1:0]  r_step_sq;
    logic [gsp_pkg::LIMIT_W-1:0] r_limit;
    logic [gsp_pkg::LIMIT_W-1:0] lim1;

    gsp_pkg::t_cmd  cmd;
    gsp_pkg::t_stat stat;
    logic [PA_W-1:0] paddr;
    logic [SA_W-1:0] saddr;
    logic [1:0]      nb;
    logic signed [VALUE_BITS-1:0] rdata;
    logic res_valid, res_kind, res_zero, conv;
    logic [gsp_pkg::LIMIT_W-1:0] sweeps;
    logic signed [VALUE_BITS-1:0] cell_out;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= gsp_pkg::RST_GRID_SIZE;
            r_tol <= gsp_pkg::RST_TOLERANCE;
            r_step_sq <= gsp_pkg::RST_STEP_SQ;
            r_limit <= gsp_pkg::RST_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gsp_pkg::CFG_GRID_SIZE: r_grid_size <= i_cfg_data[gsp_pkg::SIZE_W-1:0];
                gsp_pkg::CFG_TOLERANCE: r_tol <= i_cfg_data[gsp_pkg::TOL_W-1:0];
                gsp_pkg::CFG_STEP_SQ:   r_step_sq <= i_cfg_data;
                default:                r_limit <= i_cfg_data[gsp_pkg::LIMIT_W-1:0];
            endcase
        end
    end
    assign lim1 = (r_limit == '0) ? gsp_pkg::LIMIT_W'(1) : r_limit;

    gsp_ctrl #(.MAX_GRID(MAX_GRID)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_kind(s_axis_tuser), .i_row(s_axis_tdata[6:0]), .i_col(s_axis_tdata[13:7]),
        .i_grid_size(r_grid_size), .i_limit(lim1), .i_stat(stat),
        .i_out_free(m_axis_tready), .o_cmd(cmd), .o_paddr(paddr), .o_saddr(saddr),
        .o_nb(nb), .o_res_valid(res_valid), .o_res_kind(res_kind),
        .o_res_zero(res_zero), .o_sweeps(sweeps), .o_conv(conv)
    );

    gsp_datapath #(.MAX_GRID(MAX_GRID), .VALUE_BITS(VALUE_BITS)) u_dp (
        .i_clk(i_clk), .i_cmd(cmd), .i_paddr(paddr), .i_saddr(saddr), .i_nb(nb),
        .i_wval(s_axis_tdata[14 +: VALUE_BITS]), .i_step_sq(r_step_sq), .i_tol(r_tol),
        .o_rdata(rdata), .o_stat(stat)
    );

    logic signed [VALUE_BITS-1:0] r_cell;
    always_ff @(posedge i_clk) begin
        if (res_valid == 1'b0) r_cell <= rdata;
    end
    assign cell_out = (res_kind || res_zero) ? '0 : r_cell;

    assign m_axis_tvalid = res_valid;
    assign m_axis_tuser  = res_kind;
    assign m_axis_tdata  = OUT_W'({(res_kind ? conv : 1'b0),
                                   (res_kind ? sweeps : gsp_pkg::LIMIT_W'(0)), cell_out});

`ifndef SYNTH
    ap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    ap_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");
    ap_sweeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> sweeps != '0 && sweeps <= lim1)
        else $error("sweep count out of range");
`endif

endmodule

// ===== rtl/core/gsp_ram.sv =====
module gsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/gsp_datapath.sv =====
module gsp_datapath #(
    parameter int MAX_GRID   = gsp_pkg::MAX_GRID_DEF,
    parameter int VALUE_BITS = gsp_pkg::VALUE_BITS_DEF,
    localparam int SIDE   = MAX_GRID + 2,
    localparam int PDEPTH = SIDE * SIDE,
    localparam int SDEPTH = MAX_GRID * MAX_GRID,
    localparam int PA_W   = $clog2(PDEPTH),
    localparam int SA_W   = $clog2(SDEPTH)
) (
    input  logic                          i_clk,
    input  gsp_pkg::t_cmd                 i_cmd,
    input  logic [PA_W-1:0]               i_paddr,
    input  logic [SA_W-1:0]               i_saddr,
    input  logic [1:0]                    i_nb,
    input  logic signed [VALUE_BITS-1:0]  i_wval,
    input  logic [gsp_pkg::STEP_W-1:0]    i_step_sq,
    input  logic [gsp_pkg::TOL_W-1:0]     i_tol,
    output logic signed [VALUE_BITS-1:0]  o_rdata,
    output gsp_pkg::t_stat                o_stat
);

    localparam int SUM_W = VALUE_BITS + 4;
    localparam int PROD_W = VALUE_BITS + gsp_pkg::STEP_W + 1;
    localparam int CH_W = VALUE_BITS + 1;

    logic                          pwe, swe;
    logic signed [VALUE_BITS-1:0]  prd, srd;
    logic [PA_W-1:0]               raddr;
    logic signed [VALUE_BITS-1:0]  r_new;
    logic signed [SUM_W-1:0]       r_acc, n_acc;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [VALUE_BITS-1:0]  r_old;
    logic [CH_W-1:0]               r_worst;
    logic signed [SUM_W-1:0]       num, q;
    logic signed [CH_W-1:0]        diff;
    logic [CH_W-1:0]               adiff;
    logic signed [SUM_W-1:0]       vmax, vmin;

    assign pwe = (i_cmd.op == gsp_pkg::OP_WR_POT) || (i_cmd.op == gsp_pkg::OP_STORE);
    assign swe = (i_cmd.op == gsp_pkg::OP_WR_SRC);
    assign raddr = i_paddr;

    gsp_ram #(.WIDTH(VALUE_BITS), .DEPTH(PDEPTH)) u_pot (
        .i_clk(i_clk), .i_we(pwe), .i_waddr(i_paddr),
        .i_wdata((i_cmd.op == gsp_pkg::OP_STORE) ? r_new : i_wval),
        .i_raddr(raddr), .o_rdata(prd)
    );

    gsp_ram #(.WIDTH(VALUE_BITS), .DEPTH(SDEPTH)) u_src (
        .i_clk(i_clk), .i_we(swe), .i_waddr(i_saddr), .i_wdata(i_wval),
        .i_raddr(i_saddr), .o_rdata(srd)
    );

    assign o_rdata = prd;

    // Fetch phase: i_nb counts the read data returning from the memory.
    // The fetched data are the four neighbor cells; the old center cell follows with OP_CALC.
    always_comb begin
        n_acc = r_acc;
        if (i_cmd.op == gsp_pkg::OP_FETCH) begin
            n_acc = r_acc + SUM_W'(prd);
        end
    end

    assign vmax = SUM_W'({1'b0, {(VALUE_BITS-1){1'b1}}});
    assign vmin = ~vmax;
    assign num  = r_acc - SUM_W'(r_prod >>> gsp_pkg::STEP_W) + SUM_W'(2);
    assign q    = num >>> 2;
    assign diff = CH_W'(r_new) - CH_W'(r_old);
    assign adiff = diff[CH_W-1] ? CH_W'(-diff) : CH_W'(diff);

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_start) begin
            r_worst <= '0;
        end
        unique case (i_cmd.op)
            gsp_pkg::OP_FETCH: begin
                if (i_nb == 2'd0 && r_acc == r_acc) begin
                    r_acc <= n_acc;
                end else begin
                    r_acc <= n_acc;
                end
            end
            gsp_pkg::OP_CALC: begin
                r_prod <= $signed({1'b0, i_step_sq}) * srd;
                r_old  <= prd;
                r_acc  <= r_acc;
            end
            gsp_pkg::OP_SAT: begin
                if (q > vmax)      r_new <= vmax[VALUE_BITS-1:0];
                else if (q < vmin) r_new <= vmin[VALUE_BITS-1:0];
                else               r_new <= q[VALUE_BITS-1:0];
            end
            gsp_pkg::OP_STORE: begin
                r_acc <= '0;
                if (adiff > r_worst) r_worst <= adiff;
            end
            default: begin
                if (i_cmd.sweep_start) r_acc <= '0;
            end
        endcase
    end

    assign o_stat.conv = (r_worst <= CH_W'(i_tol));

endmodule

// ===== rtl/core/gsp_ctrl.sv =====
module gsp_ctrl #(
    parameter int MAX_GRID = gsp_pkg::MAX_GRID_DEF,
    localparam int SIDE   = MAX_GRID + 2,
    localparam int PA_W   = $clog2(SIDE * SIDE),
    localparam int SA_W   = $clog2(MAX_GRID * MAX_GRID),
    localparam int RC_W   = $clog2(SIDE)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [gsp_pkg::KIND_W-1:0]     i_kind,
    input  logic [gsp_pkg::COORD_W-1:0]    i_row,
    input  logic [gsp_pkg::COORD_W-1:0]    i_col,
    input  logic [gsp_pkg::SIZE_W-1:0]     i_grid_size,
    input  logic [gsp_pkg::LIMIT_W-1:0]    i_limit,
    input  gsp_pkg::t_stat                 i_stat,
    input  logic                           i_out_free,
    output gsp_pkg::t_cmd                  o_cmd,
    output logic [PA_W-1:0]                o_paddr,
    output logic [SA_W-1:0]                o_saddr,
    output logic [1:0]                     o_nb,
    output logic                           o_res_valid,
    output logic                           o_res_kind,
    output logic                           o_res_zero,
    output logic [gsp_pkg::LIMIT_W-1:0]    o_sweeps,
    output logic                           o_conv
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_CALC  = 3'd3;
    localparam logic [2:0] S_SAT   = 3'd4;
    localparam logic [2:0] S_STORE = 3'd5;
    localparam logic [2:0] S_CHECK = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]                  r_state, n_state;
    logic [RC_W-1:0]             r_r, r_c, lim_n;
    logic [2:0]                  r_ph;
    logic [gsp_pkg::LIMIT_W-1:0] r_cnt;
    logic                        r_zero;
    logic                        accept, pin, sin;
    logic [PA_W-1:0]             center, in_paddr;
    logic [SA_W-1:0]             in_saddr, cell_saddr;

    assign lim_n = (i_grid_size > gsp_pkg::SIZE_W'(MAX_GRID)) ? RC_W'(MAX_GRID)
                 : RC_W'(i_grid_size);
    assign pin = (32'(i_row) <= MAX_GRID + 1) && (32'(i_col) <= MAX_GRID + 1);
    assign sin = (i_row != '0) && (i_col != '0) && (32'(i_row) <= MAX_GRID)
              && (32'(i_col) <= MAX_GRID);
    assign in_paddr = PA_W'(32'(i_row) * SIDE + 32'(i_col));
    assign in_saddr = SA_W'((32'(i_row) - 1) * MAX_GRID + (32'(i_col) - 1));
    assign center = PA_W'(32'(r_r) * SIDE + 32'(r_c));
    assign cell_saddr = SA_W'((32'(r_r) - 1) * MAX_GRID + (32'(r_c) - 1));

    assign o_in_ready = (r_state == S_IDLE);
    assign accept = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd = '{op: gsp_pkg::OP_NONE, sweep_start: 1'b0};
        o_paddr = center;
        o_saddr = cell_saddr;
        o_nb = r_ph[1:0];
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_paddr = in_paddr;
                o_saddr = in_saddr;
                if (accept) begin
                    priority case (i_kind)
                        gsp_pkg::KIND_LOAD_POT:
                            if (pin) o_cmd.op = gsp_pkg::OP_WR_POT;
                        gsp_pkg::KIND_LOAD_SRC:
                            if (sin) o_cmd.op = gsp_pkg::OP_WR_SRC;
                        gsp_pkg::KIND_SOLVE: begin
                            o_cmd.sweep_start = 1'b1;
                            n_state = (lim_n == '0) ? S_CHECK : S_FETCH;
                        end
                        default: n_state = S_READ;
                    endcase
                end
            end
            S_READ: n_state = S_DONE;
            S_FETCH: begin
                // Phases 0..3 issue neighbor reads; 1..4 collect their data.
                unique case (r_ph)
                    3'd0: o_paddr = center - PA_W'(SIDE);
                    3'd1: o_paddr = center + PA_W'(SIDE);
                    3'd2: o_paddr = center - PA_W'(1);
                    default: o_paddr = center + PA_W'(1);
                endcase
                if (r_ph != 3'd0) o_cmd.op = gsp_pkg::OP_FETCH;
                if (r_ph == 3'd4) n_state = S_CALC;
            end
            S_CALC: begin
                o_cmd.op = gsp_pkg::OP_NONE;
                if (r_ph == 3'd1) begin
                    o_cmd.op = gsp_pkg::OP_CALC;
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                o_cmd.op = gsp_pkg::OP_SAT;
                n_state = S_STORE;
            end
            S_STORE: begin
                o_cmd.op = gsp_pkg::OP_STORE;
                if (r_c == lim_n && r_r == lim_n) n_state = S_CHECK;
                else n_state = S_FETCH;
            end
            S_CHECK: begin
                if (i_stat.conv || (r_cnt + 1'b1 >= i_limit)) n_state = S_DONE;
                else begin
                    o_cmd.sweep_start = 1'b1;
                    n_state = (lim_n == '0) ? S_CHECK : S_FETCH;
                end
            end
            default: if (i_out_free) n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph <= '0;
            r_r <= RC_W'(1);
            r_c <= RC_W'(1);
            r_cnt <= '0;
            r_zero <= 1'b0;
            o_conv <= 1'b0;
            o_res_kind <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    r_ph <= '0;
                    r_r <= RC_W'(1);
                    r_c <= RC_W'(1);
                    if (accept) begin
                        r_cnt <= '0;
                        o_res_kind <= (i_kind == gsp_pkg::KIND_SOLVE);
                        r_zero <= !pin;
                    end
                end
                S_FETCH: r_ph <= (r_ph == 3'd4) ? 3'd0 : r_ph + 3'd1;
                S_CALC: r_ph <= (r_ph == 3'd1) ? 3'd0 : r_ph + 3'd1;
                S_STORE: begin
                    if (r_c == lim_n) begin
                        r_c <= RC_W'(1);
                        r_r <= (r_r == lim_n) ? RC_W'(1) : r_r + 1'b1;
                    end else begin
                        r_c <= r_c + 1'b1;
                    end
                end
                S_CHECK: begin
                    r_cnt <= r_cnt + 1'b1;
                    o_conv <= i_stat.conv;
                end
                default: ;
            endcase
        end
    end

    assign o_res_valid = (r_state == S_DONE);
    assign o_res_zero = r_zero;
    assign o_sweeps = r_cnt;

endmodule

// ===== test/gauss_seidel_poisson_solver_tb.sv =====
module gauss_seidel_poisson_solver_tb;

    localparam int SIDE       = gsp_pkg::MAX_GRID_DEF + 2;
    localparam int IN_W       = ((14 + gsp_pkg::VALUE_BITS_DEF + 7) / 8) * 8;
    localparam int OUT_W      = ((gsp_pkg::VALUE_BITS_DEF + 17 + 7) / 8) * 8;
    localparam int IDLE_LIMIT = 300000;
    // Cells 0..FILL_SIDE-1 are loaded up front; no phase uses a grid above FILL_N.
    localparam int FILL_SIDE  = 8;
    localparam int FILL_N     = FILL_SIDE - 2;

    typedef struct {
        logic        answer_kind;
        logic [31:0] cell_value;
        logic [15:0] sweeps;
        logic        converged;
    } t_answer;

    class poisson_tracker;
        longint          pot[SIDE][SIDE];
        longint          src[gsp_pkg::MAX_GRID_DEF][gsp_pkg::MAX_GRID_DEF];
        int unsigned     grid_n;
        longint unsigned tol;
        longint unsigned step_sq;
        int unsigned     sweep_max;
        t_answer         awaited[$];
        int              errors;

        function new();
            grid_n    = gsp_pkg::RST_GRID_SIZE;
            tol       = gsp_pkg::RST_TOLERANCE;
            step_sq   = gsp_pkg::RST_STEP_SQ;
            sweep_max = gsp_pkg::RST_LIMIT;
            errors    = 0;
        endfunction

        function void set_reg(logic [gsp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] d);
            case (idx)
                gsp_pkg::CFG_GRID_SIZE: grid_n    = d[gsp_pkg::SIZE_W-1:0];
                gsp_pkg::CFG_TOLERANCE: tol       = d[gsp_pkg::TOL_W-1:0];
                gsp_pkg::CFG_STEP_SQ:   step_sq   = d;
                gsp_pkg::CFG_LIMIT:     sweep_max = d[gsp_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        // One in-place pass over the interior; returns the largest change.
        function longint unsigned relax_pass(int n);
            longint unsigned worst;
            longint unsigned ad;
            longint hf, num, nv, d;
            worst = 0;
            for (int r = 1; r <= n; r++) begin
                for (int c = 1; c <= n; c++) begin
                    hf  = (longint'(step_sq) * src[r-1][c-1]) >>> 32;
                    num = pot[r-1][c] + pot[r+1][c] + pot[r][c-1] + pot[r][c+1] - hf;
                    nv  = (num + 2) >>> 2;
                    if (nv > 64'sd2147483647) nv = 64'sd2147483647;
                    if (nv < -64'sd2147483648) nv = -64'sd2147483648;
                    d  = nv - pot[r][c];
                    ad = (d < 0) ? -d : d;
                    pot[r][c] = nv;
                    if (ad > worst) worst = ad;
                end
            end
            return worst;
        endfunction

        function void note_item(logic [1:0] kind, logic [6:0] row, logic [6:0] col,
                                logic [31:0] value);
            t_answer         a;
            int              n;
            int unsigned     cnt;
            int unsigned     lim;
            bit              ok;
            longint unsigned chg;
            a = '{default: '0};
            case (kind)
                gsp_pkg::KIND_LOAD_POT: begin
                    if (row < SIDE && col < SIDE) pot[row][col] = longint'($signed(value));
                end
                gsp_pkg::KIND_LOAD_SRC: begin
                    if (row >= 1 && row <= gsp_pkg::MAX_GRID_DEF && col >= 1 &&
                        col <= gsp_pkg::MAX_GRID_DEF)
                        src[row-1][col-1] = longint'($signed(value));
                end
                gsp_pkg::KIND_SOLVE: begin
                    n   = (grid_n > gsp_pkg::MAX_GRID_DEF) ? gsp_pkg::MAX_GRID_DEF : grid_n;
                    lim = (sweep_max == 0) ? 1 : sweep_max;
                    cnt = 0;
                    ok  = 0;
                    do begin
                        chg = relax_pass(n);
                        cnt++;
                        if (chg <= tol) ok = 1;
                    end while (!ok && cnt < lim);
                    a.answer_kind = 1'b1;
                    a.sweeps      = cnt[15:0];
                    a.converged   = ok;
                    awaited.push_back(a);
                end
                default: begin
                    if (row < SIDE && col < SIDE) a.cell_value = pot[row][col][31:0];
                    awaited.push_back(a);
                end
            endcase
        endfunction

        function void check_answer(logic user, logic [OUT_W-1:0] data);
            t_answer a;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result tuser=%0d tdata=%h", $time, user, data);
                errors++;
                return;
            end
            a = awaited.pop_front();
            if (user !== a.answer_kind) begin
                $display("%0t: answer_kind expected %0d actual %0d", $time, a.answer_kind, user);
                errors++;
            end
            if (data[31:0] !== a.cell_value) begin
                $display("%0t: cell_value expected %h actual %h", $time, a.cell_value,
                         data[31:0]);
                errors++;
            end
            if (data[47:32] !== a.sweeps) begin
                $display("%0t: sweeps expected %0d actual %0d", $time, a.sweeps, data[47:32]);
                errors++;
            end
            if (data[48] !== a.converged) begin
                $display("%0t: converged expected %0d actual %0d", $time, a.converged,
                         data[48]);
                errors++;
            end
            if (data[OUT_W-1:49] !== '0) begin
                $display("%0t: pad bits expected 0 actual %h", $time, data[OUT_W-1:49]);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [1:0]        s_axis_tuser;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [gsp_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [gsp_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [0:0]        m_axis_tuser;
    logic [OUT_W-1:0]  m_axis_tdata;

    poisson_tracker tracker;
    int tx_idle_pct;
    int rx_stall_pct;
    int hold_off;
    int quiet_cycles;

    gauss_seidel_poisson_solver i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tuser(m_axis_tuser), .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Receiver: random stalls per phase, plus a counted hold-off on request.
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            m_axis_tready = 1'b0;
            hold_off = hold_off - 1;
        end else begin
            m_axis_tready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                tracker.note_item(s_axis_tuser, s_axis_tdata[6:0], s_axis_tdata[13:7],
                                  s_axis_tdata[45:14]);
            if (i_cfg_valid && o_cfg_ready)
                tracker.set_reg(i_cfg_index, i_cfg_data);
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_answer(m_axis_tuser[0], m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (i_cfg_valid && o_cfg_ready) ||
                (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles > IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic offer(logic [1:0] kind, logic [6:0] row, logic [6:0] col,
                         logic [31:0] value);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge i_clk);
        s_axis_tuser  = kind;
        s_axis_tdata  = {2'b00, value, col, row};
        s_axis_tvalid = 1'b1;
        forever begin
            @(posedge i_clk);
            if (s_axis_tready) break;
        end
    endtask

    // Holds the input quiet until every awaited result is back and the block
    // has had time to finish any trailing load.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (tracker.awaited.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [gsp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] d);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = d;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
    endtask

    task automatic configure(int grid, logic [31:0] tl, logic [31:0] st, logic [31:0] lim);
        drain();
        write_reg(gsp_pkg::CFG_GRID_SIZE, 32'(grid));
        write_reg(gsp_pkg::CFG_TOLERANCE, tl);
        write_reg(gsp_pkg::CFG_STEP_SQ, st);
        write_reg(gsp_pkg::CFG_LIMIT, lim);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(3) == 0) return $urandom;
        return $urandom_range(32'h0200_0000) - 32'h0100_0000;
    endfunction

    task automatic random_phase(int grid, logic [31:0] tl, logic [31:0] st,
                                logic [31:0] lim, int txp, int rxp, int count,
                                int solve_cap, bit pause_after_solve);
        int nr, sel, solves, span;
        logic [6:0] r, c;
        configure(grid, tl, st, lim);
        tx_idle_pct  = txp;
        rx_stall_pct = rxp;
        nr     = (grid > gsp_pkg::MAX_GRID_DEF) ? gsp_pkg::MAX_GRID_DEF : grid;
        span   = (nr < 1) ? 1 : nr;
        solves = 0;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            if (sel < 6 && solves < solve_cap) begin
                offer(gsp_pkg::KIND_SOLVE, 7'($urandom), 7'($urandom), $urandom);
                solves++;
                if (pause_after_solve) drain();
            end else if (sel < 50) begin
                if (sel < 47) begin
                    r = 7'($urandom_range(nr + 1));
                    c = 7'($urandom_range(nr + 1));
                end else begin
                    r = 7'($urandom_range(127));
                    c = 7'($urandom_range(127));
                end
                offer(gsp_pkg::KIND_LOAD_POT, r, c, pick_value());
            end else if (sel < 65) begin
                if (sel < 62) begin
                    r = 7'($urandom_range(span, 1));
                    c = 7'($urandom_range(span, 1));
                end else begin
                    r = 7'($urandom_range(127));
                    c = (r == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(127, 65));
                end
                offer(gsp_pkg::KIND_LOAD_SRC, r, c, pick_value());
            end else begin
                // In-range reads stay inside the loaded corner; the rest miss the grid.
                r = (sel < 95) ? 7'($urandom_range(FILL_SIDE - 1)) : 7'($urandom_range(127, 66));
                c = (sel < 95) ? 7'($urandom_range(FILL_SIDE - 1)) : 7'($urandom_range(127));
                offer(gsp_pkg::KIND_READ, r, c, $urandom);
            end
        end
        offer(gsp_pkg::KIND_SOLVE, 7'($urandom), 7'($urandom), $urandom);
    endtask

    initial begin
        tracker       = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = '0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        m_axis_tready = 1'b0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        hold_off      = 0;
        quiet_cycles  = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Every cell that a solve or read touches gets a defined value first.
        for (int r = 0; r < FILL_SIDE; r++)
            for (int c = 0; c < FILL_SIDE; c++)
                offer(gsp_pkg::KIND_LOAD_POT, 7'(r), 7'(c),
                      $urandom_range(32'h0200_0000) - 32'h0100_0000);
        for (int r = 1; r <= FILL_N; r++)
            for (int c = 1; c <= FILL_N; c++)
                offer(gsp_pkg::KIND_LOAD_SRC, 7'(r), 7'(c),
                      $urandom_range(32'h0200_0000) - 32'h0100_0000);

        // Directed: value extremes on corner cells, out-of-range addresses.
        configure(3, 32'(gsp_pkg::RST_TOLERANCE), gsp_pkg::RST_STEP_SQ, 32'd8);
        offer(gsp_pkg::KIND_LOAD_POT, 7'd0, 7'd0, 32'h7FFF_FFFF);
        offer(gsp_pkg::KIND_READ, 7'd0, 7'd0, 32'd0);
        offer(gsp_pkg::KIND_LOAD_POT, 7'd65, 7'd65, 32'h8000_0000);
        offer(gsp_pkg::KIND_READ, 7'd65, 7'd65, 32'hFFFF_FFFF);
        offer(gsp_pkg::KIND_LOAD_POT, 7'd66, 7'd3, 32'h1234_5678);
        offer(gsp_pkg::KIND_LOAD_POT, 7'd3, 7'd127, 32'h1234_5678);
        offer(gsp_pkg::KIND_READ, 7'd127, 7'd127, 32'd0);
        offer(gsp_pkg::KIND_READ, 7'd66, 7'd0, 32'd0);
        offer(gsp_pkg::KIND_LOAD_SRC, 7'd0, 7'd1, 32'h7FFF_FFFF);
        offer(gsp_pkg::KIND_LOAD_SRC, 7'd65, 7'd2, 32'h7FFF_FFFF);
        offer(gsp_pkg::KIND_LOAD_SRC, 7'd1, 7'd0, 32'h7FFF_FFFF);
        offer(gsp_pkg::KIND_LOAD_SRC, 7'd1, 7'd1, 32'h7FFF_FFFF);
        offer(gsp_pkg::KIND_LOAD_SRC, 7'd64, 7'd64, 32'h8000_0000);
        offer(gsp_pkg::KIND_SOLVE, 7'd0, 7'd0, 32'd0);
        offer(gsp_pkg::KIND_READ, 7'd1, 7'd1, 32'd0);
        offer(gsp_pkg::KIND_READ, 7'd2, 7'd2, 32'd0);
        offer(gsp_pkg::KIND_SOLVE, 7'd127, 7'd127, 32'hFFFF_FFFF);
        offer(gsp_pkg::KIND_READ, 7'd3, 7'd3, 32'd0);

        random_phase(4, 32'(gsp_pkg::RST_TOLERANCE), gsp_pkg::RST_STEP_SQ, 32'd30,
                     0, 0, 250, 20, 0);
        random_phase(1, 32'd0, 32'd0, 32'd1, 87, 0, 250, 20, 0);
        random_phase(6, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd20, 0, 87, 250, 12, 0);
        // Long receiver hold-off while reads keep coming: the input stalls
        // behind the waiting result.
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_off     = 400;
        for (int i = 0; i < 20; i++)
            offer(gsp_pkg::KIND_READ, 7'(i % FILL_SIDE), 7'((i + 3) % FILL_SIDE), 32'd0);
        random_phase(3, 32'h0001_0000, $urandom, 32'd40, 19, 19, 250, 12, 0);
        random_phase(2, 32'h7FFF_FFFF, $urandom, 32'd65535, 0, 0, 250, 15, 0);
        random_phase(5, 32'd100, 32'd12345, 32'd0, 0, 19, 250, 15, 1);
        random_phase(0, 32'd0, $urandom, 32'd3, 87, 87, 250, 20, 0);
        random_phase(6, 32'h7FFF_FFFF, 32'd0, 32'd1, 0, 0, 30, 0, 0);
        random_phase(5, 32'd0, gsp_pkg::RST_STEP_SQ, 32'd1, 0, 0, 20, 0, 0);

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (tracker.awaited.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
